// ===== hdl/mct_pkg.sv =====
// Package for the motor capture timebase core.
// Holds shared codes, reset values, widths and the result beat type.
// No dependencies.
package mct_pkg;

   // Default channel count and slice period.
   localparam int unsigned DefChannels    = 3;
   localparam int unsigned DefSlicePeriod = 5;

   // Field and state widths.
   localparam int unsigned TimeW   = 16;
   localparam int unsigned SliceW  = 3;
   localparam int unsigned FlagW   = 3;
   localparam int unsigned SensW   = 3;
   localparam int unsigned CsrIdxW = 2;

   // Register reset values.
   localparam logic [TimeW-1:0] HalfSecondReset = 16'd10000;
   localparam logic [TimeW-1:0] LowSpeedReset   = 16'd100;
   localparam logic [TimeW-1:0] StallReset      = 16'd1000;

   // Register indexes on the write port.
   localparam logic [CsrIdxW-1:0] CsrHalfSecond = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrLowSpeed   = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrStall      = 2'd2;

   // Command codes.
   localparam logic CmdTick    = 1'b0;
   localparam logic CmdCapture = 1'b1;

   // Slice slot codes.
   typedef enum logic [1:0] {
      SliceNone     = 2'd0,
      SliceCommut   = 2'd1,
      SliceVelocity = 2'd2
   } slice_action_type;

   // Velocity mode codes.
   typedef enum logic [1:0] {
      VelNone    = 2'd0,
      VelCapture = 2'd1,
      VelTicks   = 2'd2
   } velocity_mode_type;

   // One result beat.
   typedef struct packed {
      logic              stall_res;
      logic [SensW-1:0]  stall_sensor_state;
      logic              measured_update;
      slice_action_type  slice_action;
      logic              led_toggle;
      logic [1:0]        capture_channel;
      logic [TimeW-1:0]  edge_delta;
      logic [TimeW-1:0]  previous_delta;
      logic [TimeW-1:0]  tick_delta;
      velocity_mode_type velocity_mode;
   } rsp_type;

endpackage

// ===== hdl/motor_capture_timebase_core.sv =====
// Top level of the motor capture timebase: tick and capture handling.
// Depends on mct_pkg for codes, widths and the result beat type.
//
// Channel | Direction | Ports
// req     | in        | req_valid, req_stall, req_command, req_capture_flags,
//         |           | req_edge_time, req_sensor_state
// rsp     | out       | rsp_valid, rsp_stall, rsp_stall_res ... rsp_velocity_mode
// csr     | in        | csr_write_en, csr_index, csr_data
//
// The result is computed from the state registers and the request in one pass
// and lands in the output register at the accept edge, or in the skid register
// while the output is stalled; one beat per cycle is sustained while rsp_stall is low.
// A skid register behind the output register takes one more beat while the
// output is stalled; req_stall rises only when the skid register is full.
// Reset is synchronous: clears state and valid flags, loads config reset values.
module motor_capture_timebase_core #(
   parameter int unsigned CHANNELS     = mct_pkg::DefChannels,
   parameter int unsigned SLICE_PERIOD = mct_pkg::DefSlicePeriod
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel.
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_command,
   input  logic [mct_pkg::FlagW-1:0]   req_capture_flags,
   input  logic [mct_pkg::TimeW-1:0]   req_edge_time,
   input  logic [mct_pkg::SensW-1:0]   req_sensor_state,
   // Response channel.
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_stall_res,
   output logic [mct_pkg::SensW-1:0]   rsp_stall_sensor_state,
   output logic                        rsp_measured_update,
   output logic [1:0]                  rsp_slice_action,
   output logic                        rsp_led_toggle,
   output logic [1:0]                  rsp_capture_channel,
   output logic [mct_pkg::TimeW-1:0]   rsp_edge_delta,
   output logic [mct_pkg::TimeW-1:0]   rsp_previous_delta,
   output logic [mct_pkg::TimeW-1:0]   rsp_tick_delta,
   output logic [1:0]                  rsp_velocity_mode,
   // Configuration write port.
   input  logic                        csr_write_en,
   input  logic [mct_pkg::CsrIdxW-1:0] csr_index,
   input  logic [mct_pkg::TimeW-1:0]   csr_data
);

   localparam int unsigned ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned TimeW  = mct_pkg::TimeW;
   localparam int unsigned SliceW = mct_pkg::SliceW;

   // Configuration registers.
   logic [TimeW-1:0] half_second_ff;
   logic [TimeW-1:0] low_speed_ff;
   logic [TimeW-1:0] stall_ticks_ff;

   // Timebase state.
   logic [TimeW-1:0]  tick_counter_ff, tick_counter_in;
   logic [TimeW-1:0]  last_capture_tick_ff, last_capture_tick_in;
   logic [SliceW-1:0] slice_counter_ff, slice_counter_in;
   logic              capture_pending_ff, capture_pending_in;
   logic [TimeW-1:0]  last_edge_time_ff  [CHANNELS];
   logic [TimeW-1:0]  last_edge_delta_ff [CHANNELS];

   // Output and skid registers.
   mct_pkg::rsp_type rsp_ff, rsp_in;
   mct_pkg::rsp_type skid_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             skid_valid_ff, skid_valid_in;

   logic             req_accept;
   logic             rsp_load;
   mct_pkg::rsp_type result;

   // Working signals of the single pass.
   logic [TimeW-1:0]  raw_delta;
   logic [TimeW-1:0]  tick_delta;
   logic [TimeW-1:0]  tick_inc;
   logic [SliceW-1:0] slice_inc;
   logic [CHANNELS-1:0] usable;
   logic              ch_found;
   logic [ChIdxW-1:0] ch_idx;
   logic [TimeW-1:0]  new_delta;
   logic              edge_write;

   // Handshake: the skid register holds off new beats when full.
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign rsp_load   = !rsp_valid_ff || !rsp_stall;

   // Ticks since the last capture, wrapped by the half-second count.
   always_comb begin
      raw_delta = tick_counter_ff - last_capture_tick_ff;
      if (tick_counter_ff < last_capture_tick_ff) begin
         tick_delta = raw_delta + half_second_ff;
      end else begin
         tick_delta = raw_delta;
      end
   end

   // Capture flag decode, lowest channel first.
   always_comb begin
      usable   = req_capture_flags[CHANNELS-1:0];
      ch_found = 1'b0;
      ch_idx   = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (usable[i]) begin
            ch_found = 1'b1;
            ch_idx   = ChIdxW'(i);
         end
      end
      new_delta = req_edge_time - last_edge_time_ff[ch_idx];
   end

   // Result and next state for the accepted beat.
   always_comb begin
      result               = '0;
      tick_counter_in      = tick_counter_ff;
      last_capture_tick_in = last_capture_tick_ff;
      slice_counter_in     = slice_counter_ff;
      capture_pending_in   = capture_pending_ff;
      edge_write           = 1'b0;
      tick_inc             = tick_counter_ff + TimeW'(1);
      slice_inc            = slice_counter_ff + SliceW'(1);

      if (req_command == mct_pkg::CmdTick) begin
         if (tick_delta > stall_ticks_ff) begin
            result.stall_res          = 1'b1;
            result.stall_sensor_state = req_sensor_state;
         end
         result.measured_update = capture_pending_ff;
         capture_pending_in     = 1'b0;

         case (slice_inc)
            SliceW'(1): result.slice_action = mct_pkg::SliceCommut;
            SliceW'(2): result.slice_action = mct_pkg::SliceVelocity;
            default:    result.slice_action = mct_pkg::SliceNone;
         endcase
         if (slice_inc >= SliceW'(SLICE_PERIOD)) begin
            slice_counter_in = '0;
         end else begin
            slice_counter_in = slice_inc;
         end

         if (tick_inc >= half_second_ff) begin
            result.led_toggle = 1'b1;
            tick_counter_in   = '0;
         end else begin
            tick_counter_in   = tick_inc;
         end
      end else if (ch_found) begin
         result.capture_channel = 2'(ch_idx) + 2'd1;
         result.edge_delta      = new_delta;
         result.previous_delta  = last_edge_delta_ff[ch_idx];
         result.tick_delta      = tick_delta;
         result.velocity_mode   = (tick_delta > low_speed_ff) ?
                                  mct_pkg::VelTicks : mct_pkg::VelCapture;
         edge_write             = 1'b1;
         capture_pending_in     = 1'b1;
         last_capture_tick_in   = tick_counter_ff;
      end
   end

   // Output register and skid register steering.
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_load) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            rsp_in       = result;
            rsp_valid_in = req_accept;
         end
      end else if (req_accept) begin
         skid_valid_in = 1'b1;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         half_second_ff       <= mct_pkg::HalfSecondReset;
         low_speed_ff         <= mct_pkg::LowSpeedReset;
         stall_ticks_ff       <= mct_pkg::StallReset;
         tick_counter_ff      <= '0;
         last_capture_tick_ff <= '0;
         slice_counter_ff     <= '0;
         capture_pending_ff   <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         skid_valid_ff        <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            last_edge_time_ff[i]  <= '0;
            last_edge_delta_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               mct_pkg::CsrHalfSecond: half_second_ff <= csr_data;
               mct_pkg::CsrLowSpeed:   low_speed_ff   <= csr_data;
               mct_pkg::CsrStall:      stall_ticks_ff <= csr_data;
               default: ;
            endcase
         end
         if (req_accept) begin
            tick_counter_ff      <= tick_counter_in;
            last_capture_tick_ff <= last_capture_tick_in;
            slice_counter_ff     <= slice_counter_in;
            capture_pending_ff   <= capture_pending_in;
            if (edge_write) begin
               last_edge_time_ff[ch_idx]  <= req_edge_time;
               last_edge_delta_ff[ch_idx] <= new_delta;
            end
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_accept && !rsp_load) begin
         skid_ff <= result;
      end
   end

   // Response ports.
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_stall_res          = rsp_ff.stall_res;
   assign rsp_stall_sensor_state = rsp_ff.stall_sensor_state;
   assign rsp_measured_update    = rsp_ff.measured_update;
   assign rsp_slice_action       = rsp_ff.slice_action;
   assign rsp_led_toggle         = rsp_ff.led_toggle;
   assign rsp_capture_channel    = rsp_ff.capture_channel;
   assign rsp_edge_delta         = rsp_ff.edge_delta;
   assign rsp_previous_delta     = rsp_ff.previous_delta;
   assign rsp_tick_delta         = rsp_ff.tick_delta;
   assign rsp_velocity_mode      = rsp_ff.velocity_mode;

   // The skid register only fills behind an occupied output register.
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   // The slice counter never reaches the slice period.
   a_slice_in_range: assert property (@(posedge clock) disable iff (reset)
      slice_counter_ff < SliceW'(SLICE_PERIOD))
      else $error("slice counter out of range");

   // A capture beat never carries tick fields.
   a_kinds_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.capture_channel != 2'd0) |->
      (!rsp_ff.stall_res && !rsp_ff.measured_update && !rsp_ff.led_toggle &&
       rsp_ff.slice_action == mct_pkg::SliceNone))
      else $error("capture beat carries tick fields");

   // Sensor bits are passed out only with a stall.
   a_sensor_with_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.stall_sensor_state != '0) |-> rsp_ff.stall_res)
      else $error("sensor bits without stall");

   // A captured beat leaves a pending capture for the next tick.
   a_capture_sets_pending: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_command == mct_pkg::CmdCapture && ch_found) |=>
      capture_pending_ff)
      else $error("capture did not set pending flag");

endmodule
